FILE: design/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and the B3/S23 cell rule for the life generation
// stream.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 4096;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W = 9;
	localparam int CFG_W       = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int SLOTS       = 4;

	// register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// reset values, stored as size minus one
	localparam logic [COL_W-1:0] WIDTH_M1_RST  = COL_W'(MAX_WIDTH - 1);
	localparam logic [ROW_W-1:0] HEIGHT_M1_RST = ROW_W'(64 - 1);

	// result slots of one cell, in raster order
	localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;
	localparam logic [1:0] SLOT_UP       = 2'd1;
	localparam logic [1:0] SLOT_LEFT     = 2'd2;
	localparam logic [1:0] SLOT_CORNER   = 2'd3;

	typedef struct packed {
		logic [SLOTS-1:0] mask;
		logic [SLOTS-1:0] alive;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} lgs_bundle_t;

	function automatic logic [1:0] pop3(input logic [2:0] v);
		return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
	endfunction

	// columns: bit0 top, bit1 center row, bit2 bottom
	function automatic logic life_rule(input logic [2:0] l, input logic [2:0] c,
			input logic [2:0] r);
		logic [3:0] n;
		n = {2'b00, pop3(l)} + {2'b00, pop3(c)} + {2'b00, pop3(r)} - {3'b000, c[1]};
		if (c[1])
			return (n == 4'd2) || (n == 4'd3);
		return n == 4'd3;
	endfunction

endpackage

FILE: design/lgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_front
// Takes cells in raster order, keeps the line buffer and the 3x3 window and
// forms the bundle of up to four results that each cell releases.
// ----------------------------------------------------------------------------
module lgs_front
	import lgs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cell_state,
	input  logic                q_full,
	output logic                push,
	output lgs_bundle_t         push_bundle
);

	logic [COL_W-1:0] width_m1_q;
	logic [ROW_W-1:0] height_m1_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [5:0]       window_q;

	logic             s1_valid_q;
	logic             bit_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [1:0]       rd_mem_s1;
	logic             fwd_s1;
	logic [1:0]       fwd_dat_s1;

	logic [1:0] row_mem [MAX_WIDTH];

	logic             accept;
	logic             exec;
	logic [1:0]       raw;
	logic             st0;
	logic             st1;
	logic [2:0]       nw;
	logic [2:0]       a;
	logic [2:0]       b;
	logic [1:0]       wdata;
	logic             last_row;
	logic             last_col;
	logic [COL_W-1:0] width_m1_d;
	logic [ROW_W-1:0] height_m1_d;

	assign exec     = s1_valid_q && !q_full;
	assign in_stall = s1_valid_q && !exec;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		raw      = fwd_s1 ? fwd_dat_s1 : rd_mem_s1;
		st0      = raw[0] && (row_s1 != '0);
		st1      = raw[1] && (row_s1 > ROW_W'(1));
		nw       = {bit_s1, st0, st1};
		wdata    = {st0, bit_s1};
		a        = (col_s1 == '0) ? 3'b000 : window_q[5:3];
		b        = (col_s1 == '0) ? 3'b000 : window_q[2:0];
		last_row = row_s1 == height_m1_q;
		last_col = col_s1 == width_m1_q;

		push_bundle.mask[SLOT_UP_LEFT]  = (row_s1 != '0) && (col_s1 != '0);
		push_bundle.mask[SLOT_UP]       = (row_s1 != '0) && last_col;
		push_bundle.mask[SLOT_LEFT]     = last_row && (col_s1 != '0);
		push_bundle.mask[SLOT_CORNER]   = last_row && last_col;
		push_bundle.alive[SLOT_UP_LEFT] = life_rule(a, b, nw);
		push_bundle.alive[SLOT_UP]      = life_rule(b, nw, 3'b000);
		push_bundle.alive[SLOT_LEFT]    = life_rule(a >> 1, b >> 1, nw >> 1);
		push_bundle.alive[SLOT_CORNER]  = life_rule(b >> 1, nw >> 1, 3'b000);
		push_bundle.row                 = row_s1;
		push_bundle.col                 = col_s1;
		push = exec && (push_bundle.mask != '0);
	end

	// saturate written sizes into 1..MAX, kept as size minus one
	always_comb begin
		if (cfg_data[WIDTH_REG_W-1:0] == '0)
			width_m1_d = '0;
		else if (cfg_data[WIDTH_REG_W-1:0] > WIDTH_REG_W'(MAX_WIDTH))
			width_m1_d = COL_W'(MAX_WIDTH - 1);
		else
			width_m1_d = COL_W'(cfg_data[WIDTH_REG_W-1:0] - WIDTH_REG_W'(1));
		if (cfg_data == '0)
			height_m1_d = '0;
		else if (cfg_data > CFG_W'(MAX_HEIGHT))
			height_m1_d = ROW_W'(MAX_HEIGHT - 1);
		else
			height_m1_d = ROW_W'(cfg_data - CFG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= WIDTH_M1_RST;
			height_m1_q <= HEIGHT_M1_RST;
			col_q       <= '0;
			row_q       <= '0;
			window_q    <= '0;
			s1_valid_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH)
				width_m1_q <= width_m1_d;
			else
				height_m1_q <= height_m1_d;
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
		end else begin
			if (exec)
				window_q <= {b, nw};
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (col_q == width_m1_q) begin
					col_q <= '0;
					row_q <= (row_q == height_m1_q) ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else if (exec) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec)
			row_mem[col_s1] <= wdata;
		if (accept) begin
			rd_mem_s1  <= row_mem[col_q];
			fwd_s1     <= exec && (col_s1 == col_q);
			fwd_dat_s1 <= wdata;
			bit_s1     <= cell_state;
			col_s1     <= col_q;
			row_s1     <= row_q;
		end
	end

	a_first_row_no_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && row_s1 == '0) |-> (!push_bundle.mask[SLOT_UP_LEFT]
			&& !push_bundle.mask[SLOT_UP]))
		else $error("row above reported on first row");

endmodule

FILE: design/lgs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module lgs_queue
	import lgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  lgs_bundle_t push_bundle,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output lgs_bundle_t head
);

	lgs_bundle_t       entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_bundle;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");

endmodule

FILE: design/lgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_back
// Unpacks each bundle into its results, one transfer per cycle while
// out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module lgs_back
	import lgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  lgs_bundle_t      head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             next_alive,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             frame_last
);

	logic [SLOTS-1:0] done_q;
	logic             out_valid_q;
	logic             alive_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             last_q;

	logic [SLOTS-1:0] remaining;
	logic [SLOTS-1:0] pick;
	logic [1:0]       slot;
	logic             load;
	logic             sel_alive;
	logic [ROW_W-1:0] sel_row;
	logic [COL_W-1:0] sel_col;
	logic             sel_last;

	assign remaining = head.mask & ~done_q;
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && ((remaining & ~pick) == '0);

	always_comb begin
		if (remaining[SLOT_UP_LEFT])
			slot = SLOT_UP_LEFT;
		else if (remaining[SLOT_UP])
			slot = SLOT_UP;
		else if (remaining[SLOT_LEFT])
			slot = SLOT_LEFT;
		else
			slot = SLOT_CORNER;
		pick      = SLOTS'(1) << slot;
		sel_alive = head.alive[slot];
		case (slot)
			SLOT_UP_LEFT: begin
				sel_row  = head.row - ROW_W'(1);
				sel_col  = head.col - COL_W'(1);
				sel_last = 1'b0;
			end
			SLOT_UP: begin
				sel_row  = head.row - ROW_W'(1);
				sel_col  = head.col;
				sel_last = 1'b0;
			end
			SLOT_LEFT: begin
				sel_row  = head.row;
				sel_col  = head.col - COL_W'(1);
				sel_last = 1'b0;
			end
			default: begin
				sel_row  = head.row;
				sel_col  = head.col;
				sel_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= pop ? '0 : (done_q | pick);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			alive_q <= sel_alive;
			row_q   <= sel_row;
			col_q   <= sel_col;
			last_q  <= sel_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_alive = alive_q;
	assign out_row    = row_q;
	assign out_col    = col_q;
	assign frame_last = last_q;

	a_head_not_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (remaining != '0))
		else $error("queue head has no result left");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && done_q == '0))
		else $error("bundle retired without its last result");

endmodule

FILE: design/life_generation_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stream
// One generation of the B3/S23 cellular automaton over a streamed grid.
// ----------------------------------------------------------------------------
// Cells of the current generation enter one per clock in raster order while
// in_stall is low, and each new state leaves tagged with its row and column,
// one row and one column behind the input; the last row is flushed as it
// arrives. The input takes one cell per cycle unless stalled. The output port
// carries one result per cycle while out_stall is low. Rows before the last
// yield at most one result per cell (two on their last column), the last row
// up to two (up to four on its final cell), bounded by the output register.
// A 4-entry bundle queue lets the two sides stall apart. Writing either size
// register restarts the generation at row 0, column 0; sizes saturate to
// 1..256 wide and 1..4096 high. The line buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module life_generation_stream
	import lgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cell_state,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             next_alive,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             frame_last
);

	logic        push;
	lgs_bundle_t push_bundle;
	logic        pop;
	logic        q_full;
	logic        head_valid;
	lgs_bundle_t head;

	lgs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_state  (cell_state),
		.q_full      (q_full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	lgs_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.full        (q_full),
		.head_valid  (head_valid),
		.head        (head)
	);

	lgs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.next_alive (next_alive),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule
